[rtl/tsc_pkg.sv]
package tsc_pkg;

  // grid and coordinate sizing
  localparam int SAMPLES_PER_AXIS = 4;
  localparam int COORD_BITS       = 14;
  localparam int PIXEL_BITS       = 12;
  localparam int COUNT_BITS       = 5;
  localparam int NUM_EDGES        = 3;
  localparam int NUM_SAMPLES      = SAMPLES_PER_AXIS * SAMPLES_PER_AXIS;

  // sub-pixel scale: one unit is 1/(2*SAMPLES_PER_AXIS) pixel
  localparam int SCALE      = 2 * SAMPLES_PER_AXIS;
  localparam int SCALE_BITS = $clog2(SCALE);

  // datapath widths, all exact
  localparam int VERT_W = COORD_BITS + SCALE_BITS;
  localparam int PIX_W  = PIXEL_BITS + SCALE_BITS;
  localparam int DIFF_W = ((VERT_W > PIX_W + 1) ? VERT_W : PIX_W + 1) + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int OFF_W  = DIFF_W + SCALE_BITS + 1;
  localparam int EDGE_W = PROD_W + 2;
  localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_ONLY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MULTISAMPLE  = 3'd7;

  // edge k runs from vertex k to vertex EDGE_END[k]
  localparam int EDGE_END [NUM_EDGES] = '{1, 2, 0};

  typedef logic signed [COORD_BITS-1:0] tsc_coord_t;
  typedef logic signed [VERT_W-1:0]     tsc_vert_t;
  typedef logic        [PIX_W-1:0]      tsc_pix_t;
  typedef logic signed [DIFF_W-1:0]     tsc_diff_t;
  typedef logic signed [PROD_W-1:0]     tsc_prod_t;
  typedef logic signed [OFF_W-1:0]      tsc_off_t;
  typedef logic signed [EDGE_W-1:0]     tsc_edge_t;
  typedef logic        [CNT_W-1:0]      tsc_cnt_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_x;
    logic [PIXEL_BITS-1:0] pixel_y;
  } tsc_in_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] covered_samples;
    logic                  pixel_covered;
  } tsc_out_t;

  typedef struct packed {
    logic front_only;
    logic multisample_enable;
  } tsc_mode_t;

endpackage

[rtl/tsc_sample_eval.sv]
module tsc_sample_eval (
  input  tsc_pkg::tsc_edge_t edge_val [tsc_pkg::NUM_EDGES],
  input  tsc_pkg::tsc_off_t  off_val  [tsc_pkg::NUM_EDGES][tsc_pkg::NUM_SAMPLES],
  input  tsc_pkg::tsc_off_t  ctr_val  [tsc_pkg::NUM_EDGES],
  input  tsc_pkg::tsc_mode_t mode,
  output tsc_pkg::tsc_out_t  result
);

  logic [tsc_pkg::NUM_SAMPLES-1:0] ms_in;
  logic [tsc_pkg::NUM_EDGES-1:0]   ctr_flag;
  logic                            ss_in;
  tsc_pkg::tsc_cnt_t               cnt;

  // grid samples: either facing
  for (genvar k = 0; k < tsc_pkg::NUM_SAMPLES; k++) begin : g_smp
    logic [tsc_pkg::NUM_EDGES-1:0] flag;
    for (genvar e = 0; e < tsc_pkg::NUM_EDGES; e++) begin : g_edge
      tsc_pkg::tsc_edge_t sum;
      assign sum     = edge_val[e] + tsc_pkg::tsc_edge_t'(off_val[e][k]);
      assign flag[e] = ~sum[tsc_pkg::EDGE_W-1];
    end
    assign ms_in[k] = (&flag) | ~(|flag);
  end

  // centre sample
  for (genvar e = 0; e < tsc_pkg::NUM_EDGES; e++) begin : g_ctr
    tsc_pkg::tsc_edge_t sum;
    assign sum         = edge_val[e] + tsc_pkg::tsc_edge_t'(ctr_val[e]);
    assign ctr_flag[e] = ~sum[tsc_pkg::EDGE_W-1];
  end

  assign ss_in = mode.front_only ? (&ctr_flag) : ((&ctr_flag) | ~(|ctr_flag));

  always_comb begin
    if (mode.multisample_enable) begin
      cnt = tsc_pkg::tsc_cnt_t'($countones(ms_in));
    end else begin
      cnt = tsc_pkg::tsc_cnt_t'(ss_in);
    end
  end

  assign result.covered_samples = tsc_pkg::COUNT_BITS'(cnt);
  assign result.pixel_covered   = (cnt != '0);

endmodule

[rtl/triangle_sample_coverage_unit.sv]
// registers: corner offset, product, edge value, output; throughput: one pixel
// per clock while out_ready stays high, set by the edge pipeline (differences,
// two multipliers per edge, edge value, per-sample sign test and sample count)
// reset: synchronous active-low rst_n empties the pipeline and clears all
// configuration registers to zero; no clearing pass, inputs taken straight away
module triangle_sample_coverage_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tsc_pkg::tsc_in_t                    in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output tsc_pkg::tsc_out_t                   out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  tsc_pkg::tsc_coord_t vx_r [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_coord_t vy_r [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_mode_t  mode_r;

  // scaled vertices, straight from the registers
  tsc_pkg::tsc_vert_t  vxs [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_vert_t  vys [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_pix_t   pxs;
  tsc_pkg::tsc_pix_t   pys;

  // edge terms derived from configuration, refreshed every cycle
  tsc_pkg::tsc_diff_t  dx_nxt  [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  dy_nxt  [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  dx_r    [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  dy_r    [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_off_t   off_nxt [tsc_pkg::NUM_EDGES][tsc_pkg::NUM_SAMPLES];
  tsc_pkg::tsc_off_t   off_r   [tsc_pkg::NUM_EDGES][tsc_pkg::NUM_SAMPLES];
  tsc_pkg::tsc_off_t   ctr_nxt [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_off_t   ctr_r   [tsc_pkg::NUM_EDGES];

  // pipeline payload
  tsc_pkg::tsc_diff_t  qdx_nxt [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  qdy_nxt [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  qdx_r   [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_diff_t  qdy_r   [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_prod_t  pa_r    [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_prod_t  pb_r    [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_edge_t  eb_r    [tsc_pkg::NUM_EDGES];
  tsc_pkg::tsc_out_t   res_nxt;
  tsc_pkg::tsc_out_t   out_word_r;

  // pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en_out;

  // configuration port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < tsc_pkg::NUM_EDGES; v++) begin
        vx_r[v] <= '0;
        vy_r[v] <= '0;
      end
      mode_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsc_pkg::REG_VERTEX_A_X:  vx_r[0] <= cfg_data;
        tsc_pkg::REG_VERTEX_A_Y:  vy_r[0] <= cfg_data;
        tsc_pkg::REG_VERTEX_B_X:  vx_r[1] <= cfg_data;
        tsc_pkg::REG_VERTEX_B_Y:  vy_r[1] <= cfg_data;
        tsc_pkg::REG_VERTEX_C_X:  vx_r[2] <= cfg_data;
        tsc_pkg::REG_VERTEX_C_Y:  vy_r[2] <= cfg_data;
        tsc_pkg::REG_FRONT_ONLY:  mode_r.front_only <= cfg_data[0];
        tsc_pkg::REG_MULTISAMPLE: mode_r.multisample_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // vertices and pixel corner in sub-pixel units
  always_comb begin
    for (int v = 0; v < tsc_pkg::NUM_EDGES; v++) begin
      vxs[v] = tsc_pkg::tsc_vert_t'(vx_r[v]) * tsc_pkg::tsc_vert_t'(tsc_pkg::SCALE);
      vys[v] = tsc_pkg::tsc_vert_t'(vy_r[v]) * tsc_pkg::tsc_vert_t'(tsc_pkg::SCALE);
    end
  end

  assign pxs = tsc_pkg::tsc_pix_t'(in_word.pixel_x) * tsc_pkg::tsc_pix_t'(tsc_pkg::SCALE);
  assign pys = tsc_pkg::tsc_pix_t'(in_word.pixel_y) * tsc_pkg::tsc_pix_t'(tsc_pkg::SCALE);

  // edge direction per edge, end minus start
  always_comb begin
    for (int e = 0; e < tsc_pkg::NUM_EDGES; e++) begin
      dx_nxt[e] = tsc_pkg::tsc_diff_t'(vxs[tsc_pkg::EDGE_END[e]]) - tsc_pkg::tsc_diff_t'(vxs[e]);
      dy_nxt[e] = tsc_pkg::tsc_diff_t'(vys[tsc_pkg::EDGE_END[e]]) - tsc_pkg::tsc_diff_t'(vys[e]);
    end
  end

  // edge function is linear, so each sample is the corner value plus a fixed step:
  // dx*(2j+1) - dy*(2i+1) for the grid, dx*n - dy*n for the centre
  always_comb begin
    for (int e = 0; e < tsc_pkg::NUM_EDGES; e++) begin
      for (int i = 0; i < tsc_pkg::SAMPLES_PER_AXIS; i++) begin
        for (int j = 0; j < tsc_pkg::SAMPLES_PER_AXIS; j++) begin
          off_nxt[e][i * tsc_pkg::SAMPLES_PER_AXIS + j] =
            tsc_pkg::tsc_off_t'(dx_r[e]) * tsc_pkg::tsc_off_t'(2 * j + 1) -
            tsc_pkg::tsc_off_t'(dy_r[e]) * tsc_pkg::tsc_off_t'(2 * i + 1);
        end
      end
      ctr_nxt[e] =
        tsc_pkg::tsc_off_t'(dx_r[e]) * tsc_pkg::tsc_off_t'(tsc_pkg::SAMPLES_PER_AXIS) -
        tsc_pkg::tsc_off_t'(dy_r[e]) * tsc_pkg::tsc_off_t'(tsc_pkg::SAMPLES_PER_AXIS);
    end
  end

  always_ff @(posedge clk) begin
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    off_r   <= off_nxt;
    ctr_r   <= ctr_nxt;
  end

  // pixel corner relative to each edge start
  always_comb begin
    for (int e = 0; e < tsc_pkg::NUM_EDGES; e++) begin
      qdx_nxt[e] = tsc_pkg::tsc_diff_t'(pxs) - tsc_pkg::tsc_diff_t'(vxs[e]);
      qdy_nxt[e] = tsc_pkg::tsc_diff_t'(pys) - tsc_pkg::tsc_diff_t'(vys[e]);
    end
  end

  // stall chain: a stage loads when it is empty or its word moves on
  assign en_out   = !out_valid_r || out_ready;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // stage 1: corner offsets; stage 2: products; stage 3: corner edge value
  always_ff @(posedge clk) begin
    if (en1) begin
      qdx_r <= qdx_nxt;
      qdy_r <= qdy_nxt;
    end
    if (en2) begin
      for (int e = 0; e < tsc_pkg::NUM_EDGES; e++) begin
        pa_r[e] <= tsc_pkg::tsc_prod_t'(dx_r[e]) * tsc_pkg::tsc_prod_t'(qdy_r[e]);
        pb_r[e] <= tsc_pkg::tsc_prod_t'(dy_r[e]) * tsc_pkg::tsc_prod_t'(qdx_r[e]);
      end
    end
    if (en3) begin
      for (int e = 0; e < tsc_pkg::NUM_EDGES; e++) begin
        eb_r[e] <= tsc_pkg::tsc_edge_t'(pa_r[e]) - tsc_pkg::tsc_edge_t'(pb_r[e]);
      end
    end
    if (en_out) begin
      out_word_r <= res_nxt;
    end
  end

  // sign tests and sample count
  tsc_sample_eval u_eval (
    .edge_val (eb_r),
    .off_val  (off_r),
    .ctr_val  (ctr_r),
    .mode     (mode_r),
    .result   (res_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef NO_ASSERTIONS
  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r && !v3_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // a stalled word in stage 1 is not lost
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !en2 |=> v1_r)
    else $error("stage 1 word dropped under stall");

  // a word leaving stage 1 lands in stage 2
  a_s1_move: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && en2 |=> v2_r)
    else $error("stage 1 word lost on advance");

  // last stage feeds the output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && en_out |=> out_valid_r)
    else $error("result word lost entering output register");

  // a non-zero count always marks the pixel covered
  a_cover_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_word_r.covered_samples != '0) |-> out_word_r.pixel_covered)
    else $error("pixel_covered disagrees with covered_samples");
`endif

endmodule

[tb/tsc_coverage_checker.sv]
`timescale 1ns / 100ps

module tsc_coverage_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  tsc_pkg::tsc_in_t                 in_word,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  tsc_pkg::tsc_out_t                out_word,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               pending_words,
  output int                               error_count,
  output int                               words_checked,
  output int                               covered_words
);

  localparam longint SC = tsc_pkg::SCALE;
  localparam int GRID = tsc_pkg::SAMPLES_PER_AXIS;

  // mirror of the block's registers, vertices in whole pixels
  longint vert_x [3];
  longint vert_y [3];
  logic   front_only_mode;
  logic   grid_mode;

  tsc_pkg::tsc_out_t coverage_q [$];

  initial begin
    pending_words = 0;
    error_count   = 0;
    words_checked = 0;
    covered_words = 0;
  end

  function automatic longint coord_of(logic [tsc_pkg::CFG_DATA_W-1:0] d);
    tsc_pkg::tsc_coord_t c;
    c = d[tsc_pkg::COORD_BITS-1:0];
    return longint'(c);
  endfunction

  // sign of the edge cross product, zero counts as inside
  function automatic logic edge_nonneg(longint sx, longint sy, longint ex, longint ey,
                                       longint qx, longint qy);
    longint e;
    e = (ex - sx) * (qy - sy) - (ey - sy) * (qx - sx);
    return e >= 0;
  endfunction

  function automatic logic sample_inside(longint qx, longint qy, logic front);
    logic [2:0] side;
    int         n;
    for (int k = 0; k < 3; k++) begin
      n = (k + 1) % 3;
      side[k] = edge_nonneg(vert_x[k] * SC, vert_y[k] * SC, vert_x[n] * SC, vert_y[n] * SC,
                            qx, qy);
    end
    if (front)
      return &side;
    return (&side) || (side == 3'b000);
  endfunction

  function automatic tsc_pkg::tsc_out_t predict_coverage(tsc_pkg::tsc_in_t p);
    tsc_pkg::tsc_out_t r;
    longint            px;
    longint            py;
    int                hits;
    px   = longint'(p.pixel_x) * SC;
    py   = longint'(p.pixel_y) * SC;
    hits = 0;
    if (grid_mode) begin
      // grid ignores front_only
      for (int i = 0; i < GRID; i++)
        for (int j = 0; j < GRID; j++)
          if (sample_inside(px + 2 * i + 1, py + 2 * j + 1, 1'b0))
            hits++;
    end else if (sample_inside(px + GRID, py + GRID, front_only_mode)) begin
      hits = 1;
    end
    r.covered_samples = hits[tsc_pkg::COUNT_BITS-1:0];
    r.pixel_covered   = (hits != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    tsc_pkg::tsc_out_t want;
    if (!rst_n) begin
      foreach (vert_x[k]) begin
        vert_x[k] = 0;
        vert_y[k] = 0;
      end
      front_only_mode = 1'b0;
      grid_mode       = 1'b0;
      coverage_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsc_pkg::REG_VERTEX_A_X:  vert_x[0] = coord_of(cfg_data);
          tsc_pkg::REG_VERTEX_A_Y:  vert_y[0] = coord_of(cfg_data);
          tsc_pkg::REG_VERTEX_B_X:  vert_x[1] = coord_of(cfg_data);
          tsc_pkg::REG_VERTEX_B_Y:  vert_y[1] = coord_of(cfg_data);
          tsc_pkg::REG_VERTEX_C_X:  vert_x[2] = coord_of(cfg_data);
          tsc_pkg::REG_VERTEX_C_Y:  vert_y[2] = coord_of(cfg_data);
          tsc_pkg::REG_FRONT_ONLY:  front_only_mode = cfg_data[0];
          tsc_pkg::REG_MULTISAMPLE: grid_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (coverage_q.size() == 0) begin
          $display("%0t: coverage word cs=%0d pc=%0b arrived with none outstanding",
                   $time, out_word.covered_samples, out_word.pixel_covered);
          error_count++;
        end else begin
          want = coverage_q.pop_front();
          words_checked++;
          if (out_word.pixel_covered)
            covered_words++;
          if (out_word.covered_samples !== want.covered_samples) begin
            $display("%0t: covered_samples expected %0d actual %0d",
                     $time, want.covered_samples, out_word.covered_samples);
            error_count++;
          end
          if (out_word.pixel_covered !== want.pixel_covered) begin
            $display("%0t: pixel_covered expected %0b actual %0b",
                     $time, want.pixel_covered, out_word.pixel_covered);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready)
        coverage_q.push_back(predict_coverage(in_word));
    end
    pending_words = coverage_q.size();
  end

endmodule

[tb/tb_triangle_sample_coverage_unit.sv]
`timescale 1ns / 100ps

module tb_triangle_sample_coverage_unit;

  localparam int RESET_CYCLES = 6;
  localparam int PIPE_LATENCY = 3;
  // the cycle limit leaves plenty of headroom over the slowest legal run
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PIXEL    = (1 << tsc_pkg::PIXEL_BITS) - 1;
  localparam int COORD_LO     = -(1 << (tsc_pkg::COORD_BITS - 1));
  localparam int COORD_HI     = (1 << (tsc_pkg::COORD_BITS - 1)) - 1;
  localparam int WORDS_PER_TRI = 135;

  // everything the block sees is known from time zero
  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  tsc_pkg::tsc_in_t                    in_word   = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  tsc_pkg::tsc_out_t                   out_word;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [tsc_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

  // idling odds in percent, changed per phase
  int send_idle_pct = 9;
  int recv_idle_pct = 80;
  int cycle_count   = 0;
  int triangles_used = 0;

  // pixel window around the current triangle, used for most random pixels
  int box_x0 = 0;
  int box_x1 = MAX_PIXEL;
  int box_y0 = 0;
  int box_y1 = MAX_PIXEL;

  int pending_words;
  int error_count;
  int words_checked;
  int covered_words;

  triangle_sample_coverage_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsc_coverage_checker coverage_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending_words (pending_words),
    .error_count   (error_count),
    .words_checked (words_checked),
    .covered_words (covered_words)
  );

  initial forever #2 clk = ~clk;

  // receiver back-pressure, one decision per cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic tsc_pkg::tsc_in_t pixel_at(int x, int y);
    tsc_pkg::tsc_in_t w;
    w.pixel_x = x[tsc_pkg::PIXEL_BITS-1:0];
    w.pixel_y = y[tsc_pkg::PIXEL_BITS-1:0];
    return w;
  endfunction

  function automatic int clamp_pixel(int v);
    return (v < 0) ? 0 : ((v > MAX_PIXEL) ? MAX_PIXEL : v);
  endfunction

  // mostly pixels around the triangle so the edges get crossed, the rest anywhere
  function automatic tsc_pkg::tsc_in_t random_pixel();
    if ($urandom_range(0, 7) == 0)
      return pixel_at($urandom_range(0, MAX_PIXEL), $urandom_range(0, MAX_PIXEL));
    return pixel_at($urandom_range(box_x0, box_x1), $urandom_range(box_y0, box_y1));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance with
  // valid still high so back-to-back words need no lowering
  task automatic send_pixel(tsc_pkg::tsc_in_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // lower the input and wait until every coverage word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
  endtask

  task automatic write_reg(logic [tsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsc_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                               logic front, logic grid);
    logic [tsc_pkg::CFG_DATA_W-1:0] mode_word;
    int lo_x, hi_x, lo_y, hi_y;
    write_reg(tsc_pkg::REG_VERTEX_A_X, tsc_pkg::CFG_DATA_W'(ax));
    write_reg(tsc_pkg::REG_VERTEX_A_Y, tsc_pkg::CFG_DATA_W'(ay));
    write_reg(tsc_pkg::REG_VERTEX_B_X, tsc_pkg::CFG_DATA_W'(bx));
    write_reg(tsc_pkg::REG_VERTEX_B_Y, tsc_pkg::CFG_DATA_W'(by));
    write_reg(tsc_pkg::REG_VERTEX_C_X, tsc_pkg::CFG_DATA_W'(cx));
    write_reg(tsc_pkg::REG_VERTEX_C_Y, tsc_pkg::CFG_DATA_W'(cy));
    // junk in the upper bits of the mode registers must be ignored
    mode_word    = $urandom;
    mode_word[0] = front;
    write_reg(tsc_pkg::REG_FRONT_ONLY, mode_word);
    mode_word    = $urandom;
    mode_word[0] = grid;
    write_reg(tsc_pkg::REG_MULTISAMPLE, mode_word);
    cfg_valid <= 1'b0;
    triangles_used++;
    // bounding box plus a couple of pixels, clipped to the pixel range
    lo_x = clamp_pixel(((ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx)) - 2);
    hi_x = clamp_pixel(((ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx)) + 2);
    lo_y = clamp_pixel(((ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy)) - 2);
    hi_y = clamp_pixel(((ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy)) + 2);
    if (lo_x == hi_x || lo_y == hi_y) begin
      // triangle sits off the pixel range, sweep everything instead
      lo_x = 0;
      hi_x = MAX_PIXEL;
      lo_y = 0;
      hi_y = MAX_PIXEL;
    end
    box_x0 = lo_x;
    box_x1 = hi_x;
    box_y0 = lo_y;
    box_y1 = hi_y;
  endtask

  function automatic int extreme_coord();
    case ($urandom_range(0, 2))
      0:       return COORD_LO;
      1:       return COORD_HI;
      default: return int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
    endcase
  endfunction

  // shapes: small near the pixel range, anywhere, degenerate, mostly pinned to the extremes
  task automatic random_triangle(int shape, logic front, logic grid);
    int v [6];
    int ox, oy, span, dx, dy;
    case (shape)
      0: begin
        ox   = $urandom_range(0, MAX_PIXEL);
        oy   = $urandom_range(0, MAX_PIXEL);
        span = $urandom_range(1, 24);
        for (int k = 0; k < 6; k += 2) begin
          v[k]     = ox + int'($urandom_range(0, 2 * span)) - span;
          v[k + 1] = oy + int'($urandom_range(0, 2 * span)) - span;
        end
      end
      1: begin
        foreach (v[k])
          v[k] = int'($urandom_range(0, COORD_HI - COORD_LO)) + COORD_LO;
      end
      2: begin
        // collinear, sometimes all three on one point
        ox = $urandom_range(0, MAX_PIXEL);
        oy = $urandom_range(0, MAX_PIXEL);
        dx = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16)) - 8;
        dy = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16)) - 8;
        v[0] = ox;
        v[1] = oy;
        span = int'($urandom_range(0, 100)) - 50;
        v[2] = ox + span * dx;
        v[3] = oy + span * dy;
        span = int'($urandom_range(0, 100)) - 50;
        v[4] = ox + span * dx;
        v[5] = oy + span * dy;
      end
      default: begin
        foreach (v[k])
          v[k] = extreme_coord();
      end
    endcase
    load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], front, grid);
  endtask

  // timeout guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit with %0d words outstanding", pending_words);
    $display("triangle_sample_coverage_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // registers at reset: all vertices on the origin, so everything is covered
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(MAX_PIXEL, MAX_PIXEL));
    send_pixel(pixel_at(0, MAX_PIXEL));
    send_pixel(pixel_at(MAX_PIXEL, 0));

    // counterclockwise right triangle, grid: full, on-edge, partial and outside pixels
    drain();
    load_triangle(0, 0, 16, 0, 0, 16, 1'b0, 1'b1);
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(7, 8));
    send_pixel(pixel_at(8, 7));
    send_pixel(pixel_at(20, 20));
    send_pixel(pixel_at(15, 0));

    // same triangle, centre sample with front-only; (7,8) has its centre on the hypotenuse
    drain();
    load_triangle(0, 0, 16, 0, 0, 16, 1'b1, 1'b0);
    send_pixel(pixel_at(7, 8));
    send_pixel(pixel_at(3, 3));
    send_pixel(pixel_at(30, 30));

    // clockwise winding: rejected by front-only, taken by either facing
    drain();
    load_triangle(0, 0, 0, 16, 16, 0, 1'b1, 1'b0);
    send_pixel(pixel_at(3, 3));
    drain();
    load_triangle(0, 0, 0, 16, 16, 0, 1'b0, 1'b0);
    send_pixel(pixel_at(3, 3));

    // front-only has no say in grid mode
    drain();
    load_triangle(0, 0, 0, 16, 16, 0, 1'b1, 1'b1);
    send_pixel(pixel_at(3, 3));
    send_pixel(pixel_at(7, 8));

    // vertices at the register extremes
    drain();
    load_triangle(COORD_LO, COORD_LO, COORD_HI, COORD_LO, COORD_LO, COORD_HI, 1'b0, 1'b1);
    send_pixel(pixel_at(MAX_PIXEL, MAX_PIXEL));
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(MAX_PIXEL, 0));

    // collinear vertices
    drain();
    load_triangle(0, 0, 10, 10, 20, 20, 1'b0, 1'b1);
    send_pixel(pixel_at(5, 5));
    send_pixel(pixel_at(100, 3));

    // random part: three idling phases, four triangles each covering all mode pairs
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int t = 0; t < 4; t++) begin
        drain();
        random_triangle((t + phase) % 4, t[1], t[0]);
        repeat (WORDS_PER_TRI) send_pixel(random_pixel());
      end
    end

    drain();
    // let any stray word show up
    repeat (PIPE_LATENCY + 5) @(posedge clk);

    $display("checked %0d coverage words over %0d triangle settings, %0d pixels covered",
             words_checked, triangles_used, covered_words);
    $display("grid and centre sampling, both facings, degenerate and extreme triangles");
    if (error_count == 0 && pending_words == 0)
      $display("triangle_sample_coverage_unit verification clean");
    else
      $display("triangle_sample_coverage_unit verification failed");
    $finish;
  end

endmodule
